### src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// Line scan converter package
// Grid constants, the walk command handed from the front end to the walker,
// and the coordinate helper functions.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int GRID_SIZE = 64;
  localparam int FRAC_BITS = 4;
  localparam int IN_W      = 10;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int RND_W     = IN_W - FRAC_BITS + 1;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  // The error term can grow by twice the minor span on every step of a walk
  // whose rounded minor span exceeds the major span.
  localparam int ERR_W     = 2 * IDX_W + 3;

  // Command queue between the front end and the walker.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic             row_walk;
    logic             minor_down;
    logic [IDX_W-1:0] major0;
    logic [IDX_W-1:0] major1;
    logic [IDX_W-1:0] minor0;
    logic [IDX_W-1:0] dmaj;
    logic [IDX_W-1:0] dmin;
  } lsc_cmd_t;

  // Round half up to a grid index and limit it to the last grid cell.
  function automatic logic [IDX_W-1:0] round_idx(input logic [IN_W-1:0] v);
    logic [IN_W:0]    sum;
    logic [RND_W-1:0] r;
    sum = {1'b0, v} + (IN_W + 1)'(HALF);
    r   = sum[IN_W:FRAC_BITS];
    if (r > RND_W'(GRID_SIZE - 1)) begin
      round_idx = IDX_W'(GRID_SIZE - 1);
    end else begin
      round_idx = r[IDX_W-1:0];
    end
  endfunction

  function automatic logic [IN_W-1:0] abs_diff(input logic [IN_W-1:0] a,
                                               input logic [IN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### src/lsc_seg_if.sv
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel that carries one line segment, two fixed point endpoints.
// ----------------------------------------------------------------------------
interface lsc_seg_if import lsc_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] start_row;
  logic [IN_W-1:0] start_col;
  logic [IN_W-1:0] end_row;
  logic [IN_W-1:0] end_col;

  modport source (output valid, output start_row, output start_col,
                  output end_row, output end_col, input ready);
  modport sink   (input valid, input start_row, input start_col,
                  input end_row, input end_col, output ready);

endinterface

### src/lsc_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one grid cell and its end-of-segment flag.
// ----------------------------------------------------------------------------
interface lsc_pix_if import lsc_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_row;
  logic [IDX_W-1:0] pixel_col;
  logic             last;

  modport source (output valid, output pixel_row, output pixel_col,
                  output last, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col,
                  input last, output ready);

endinterface

### src/line_scan_converter.sv
// ----------------------------------------------------------------------------
// Line scan converter
// Turns line segments with fixed point endpoints into the ordered list of
// grid cells that a Bresenham walk sets.
// ----------------------------------------------------------------------------
// Usage:
//   A segment arrives on seg_i as four unsigned coordinates with four
//   fraction bits. Each transfer on seg_i yields one to 64 transfers on
//   pix_o, one per grid cell, in walk order; the final cell carries last.
//   The front end rounds and registers the endpoints, orders them and
//   queues a walk command; the walker then emits one cell per cycle while
//   the receiver keeps ready high. The walker loads the next queued
//   command in the cycle that it emits the last cell of the current one,
//   so cells of consecutive segments follow without a gap. The walker's
//   single step per cycle sets this rate; the front end takes a new
//   segment whenever its stage register can drain into the two-entry queue.
//   Reset clears the stage, queue and walker valids; no transfer is pending.
//   When the receiver holds ready low the output register keeps its cell,
//   the walker freezes, the queue fills, and then seg_i drops ready.
// ----------------------------------------------------------------------------
module line_scan_converter import lsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_seg_if.sink   seg_i,
  lsc_pix_if.source pix_o
);

  // Front end to queue.
  logic     fq_valid, fq_ready;
  lsc_cmd_t fq_cmd;

  // Queue to walker.
  logic     qw_valid, qw_ready;
  lsc_cmd_t qw_cmd;

  lsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  lsc_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qw_valid),
    .pop_ready_i  (qw_ready),
    .pop_data_o   (qw_cmd)
  );

  lsc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qw_valid),
    .cmd_ready_o (qw_ready),
    .cmd_i       (qw_cmd),
    .pix_o       (pix_o)
  );

endmodule

### src/lsc_front.sv
// ----------------------------------------------------------------------------
// Line scan converter front end
// Rounds the endpoints, picks the walk axis and orders the endpoints, then
// pushes one walk command per segment.
// ----------------------------------------------------------------------------
module lsc_front import lsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsc_seg_if.sink       seg_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output lsc_cmd_t      cmd_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [IDX_W-1:0] r0_q, c0_q, r1_q, c1_q;
  logic [IN_W-1:0]  drow_q, dcol_q;
  logic             accept;

  logic             row_walk, swap;
  logic [IDX_W-1:0] maj0, maj1, mn0, mn1;
  logic [IDX_W-1:0] s_maj0, s_maj1, s_mn0, s_mn1;

  assign seg_i.ready = !s1_valid_q || cmd_ready_i;
  assign accept      = seg_i.valid && seg_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r0_q   <= round_idx(seg_i.start_row);
      c0_q   <= round_idx(seg_i.start_col);
      r1_q   <= round_idx(seg_i.end_row);
      c1_q   <= round_idx(seg_i.end_col);
      drow_q <= abs_diff(seg_i.start_row, seg_i.end_row);
      dcol_q <= abs_diff(seg_i.start_col, seg_i.end_col);
    end
  end

  // A vertical or horizontal segment is a walk with a zero minor span.
  assign row_walk = (c0_q == c1_q) || ((r0_q != r1_q) && (dcol_q < drow_q));
  assign maj0     = row_walk ? r0_q : c0_q;
  assign maj1     = row_walk ? r1_q : c1_q;
  assign mn0      = row_walk ? c0_q : r0_q;
  assign mn1      = row_walk ? c1_q : r1_q;
  assign swap     = maj0 > maj1;
  assign s_maj0   = swap ? maj1 : maj0;
  assign s_maj1   = swap ? maj0 : maj1;
  assign s_mn0    = swap ? mn1 : mn0;
  assign s_mn1    = swap ? mn0 : mn1;

  always_comb begin
    cmd_o.row_walk   = row_walk;
    cmd_o.minor_down = s_mn1 < s_mn0;
    cmd_o.major0     = s_maj0;
    cmd_o.major1     = s_maj1;
    cmd_o.minor0     = s_mn0;
    cmd_o.dmaj       = s_maj1 - s_maj0;
    cmd_o.dmin       = (s_mn1 < s_mn0) ? (s_mn0 - s_mn1) : (s_mn1 - s_mn0);
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

### src/lsc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Line scan converter command queue
// Two-entry queue of walk commands between the front end and the walker.
// ----------------------------------------------------------------------------
module lsc_cmd_fifo import lsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  lsc_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output lsc_cmd_t pop_data_o
);

  lsc_cmd_t             mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = count_q != CMD_CNT_W'(CMD_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : (wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : (rd_ptr_q + 1'b1);
    end
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/lsc_walker.sv
// ----------------------------------------------------------------------------
// Line scan converter walker
// Steps one walk command along its major axis, one cell per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module lsc_walker import lsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  lsc_cmd_t cmd_i,
  lsc_pix_if.source pix_o
);

  lsc_cmd_t         cmd_q;
  logic             busy_q, busy_d;
  logic [IDX_W-1:0] a_q, a_d, b_q, b_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic             out_last_q;

  logic             emit, at_end, load, err_pos;

  assign emit        = busy_q && (!out_valid_q || pix_o.ready);
  assign at_end      = a_q == cmd_q.major1;
  assign cmd_ready_o = !busy_q || (emit && at_end);
  assign load        = cmd_valid_i && cmd_ready_o;
  assign err_pos     = !err_q[ERR_W-1] && (err_q != '0);

  always_comb begin
    busy_d      = busy_q;
    a_d         = a_q;
    b_d         = b_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      a_d         = a_q + 1'b1;
      err_d       = err_q + ERR_W'({cmd_q.dmin, 1'b0})
                  - (err_pos ? ERR_W'({cmd_q.dmaj, 1'b0}) : '0);
      if (err_pos) begin
        b_d = cmd_q.minor_down ? (b_q - 1'b1) : (b_q + 1'b1);
      end
      if (at_end) begin
        busy_d = 1'b0;
      end
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      a_d    = cmd_i.major0;
      b_d    = cmd_i.minor0;
      err_d  = ERR_W'({cmd_i.dmin, 1'b0}) - ERR_W'(cmd_i.dmaj);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    err_q <= err_d;
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_row_q  <= cmd_q.row_walk ? a_q : b_q;
      out_col_q  <= cmd_q.row_walk ? b_q : a_q;
      out_last_q <= at_end;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.pixel_row = out_row_q;
  assign pix_o.pixel_col = out_col_q;
  assign pix_o.last      = out_last_q;

  // The walk never passes the far end of its major span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> a_q <= cmd_q.major1)
    else $error("walker ran past the end of its major span");

  // A stalled output freezes the walk position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_valid_q && !pix_o.ready |=> $stable(a_q) && $stable(b_q))
    else $error("walker advanced while the output was stalled");

  // The final cell of a walk leaves the output register flagged as last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && at_end |=> out_valid_q && out_last_q)
    else $error("final cell of a walk not flagged as last");

  // Every other cell is presented without the last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !at_end |=> out_valid_q && !out_last_q)
    else $error("last flag set before the end of a walk");

endmodule

### test/lsc_cell_checker.sv
// ----------------------------------------------------------------------------
// Line scan converter cell checker
// Watches the segment and pixel channels and predicts the cells of every
// accepted segment. Each pixel transfer is compared with the oldest predicted
// cell, and the mismatch count goes back to the testbench top.
// ----------------------------------------------------------------------------
module lsc_cell_checker import lsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lsc_seg_if    seg,
  lsc_pix_if    pix,
  output int    mismatch_count,
  output int    cells_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } cell_t;

  cell_t expected_cells[$];

  initial begin
    mismatch_count = 0;
    cells_pending  = 0;
  end

  // Round half up to a grid index, limited to the last cell of the grid.
  function automatic int to_cell(input logic [IN_W-1:0] v);
    int r;
    r = (int'(v) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > GRID_SIZE - 1) begin
      r = GRID_SIZE - 1;
    end
    return r;
  endfunction

  function automatic void push_cell(input int row, input int col, input bit last);
    cell_t c;
    c.row  = IDX_W'(row);
    c.col  = IDX_W'(col);
    c.last = last;
    expected_cells.push_back(c);
  endfunction

  // Queue every cell that the scan of one segment sets, in walk order.
  function automatic void expand_segment(input logic [IN_W-1:0] sr, input logic [IN_W-1:0] sc,
                                         input logic [IN_W-1:0] er, input logic [IN_W-1:0] ec);
    int r0, c0, r1, c1, t;
    int drow_raw, dcol_raw;
    int maj0, maj1, min0, min1, dmaj, dmin, stp, err, a, b;
    bit by_row;
    r0 = to_cell(sr);
    c0 = to_cell(sc);
    r1 = to_cell(er);
    c1 = to_cell(ec);
    if (c0 == c1) begin
      if (r0 > r1) begin
        t = r0; r0 = r1; r1 = t;
      end
      for (t = r0; t <= r1; t++) begin
        push_cell(t, c0, t == r1);
      end
    end else if (r0 == r1) begin
      if (c0 > c1) begin
        t = c0; c0 = c1; c1 = t;
      end
      for (t = c0; t <= c1; t++) begin
        push_cell(r0, t, t == c1);
      end
    end else begin
      // The walk direction comes from the raw differences, not the rounded ones.
      drow_raw = (sr > er) ? int'(sr) - int'(er) : int'(er) - int'(sr);
      dcol_raw = (sc > ec) ? int'(sc) - int'(ec) : int'(ec) - int'(sc);
      by_row   = dcol_raw < drow_raw;
      if (by_row) begin
        maj0 = r0; min0 = c0; maj1 = r1; min1 = c1;
      end else begin
        maj0 = c0; min0 = r0; maj1 = c1; min1 = r1;
      end
      if (maj0 > maj1) begin
        t = maj0; maj0 = maj1; maj1 = t;
        t = min0; min0 = min1; min1 = t;
      end
      dmaj = maj1 - maj0;
      dmin = min1 - min0;
      stp  = 1;
      if (dmin < 0) begin
        stp  = -1;
        dmin = -dmin;
      end
      err = 2 * dmin - dmaj;
      b   = min0;
      for (a = maj0; a <= maj1; a++) begin
        if (by_row) begin
          push_cell(a, b, a == maj1);
        end else begin
          push_cell(b, a, a == maj1);
        end
        if (err > 0) begin
          b   = b + stp;
          err = err - 2 * dmaj;
        end
        err = err + 2 * dmin;
      end
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    cell_t want;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected cell: pixel_row %0d pixel_col %0d last %0d",
                 pix.pixel_row, pix.pixel_col, pix.last);
          mismatch_count++;
        end else begin
          want = expected_cells.pop_front();
          if (pix.pixel_row !== want.row) begin
            $error("pixel_row expected %0d actual %0d", want.row, pix.pixel_row);
            mismatch_count++;
          end
          if (pix.pixel_col !== want.col) begin
            $error("pixel_col expected %0d actual %0d", want.col, pix.pixel_col);
            mismatch_count++;
          end
          if (pix.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, pix.last);
            mismatch_count++;
          end
        end
      end
      if (seg.valid && seg.ready) begin
        expand_segment(seg.start_row, seg.start_col, seg.end_row, seg.end_col);
      end
    end
    cells_pending <= expected_cells.size();
  end

endmodule

### test/tb_line_scan_converter.sv
// ----------------------------------------------------------------------------
// Line scan converter testbench
// Sends directed and random line segments into the converter, with random
// gaps on the segment channel and random back pressure on the pixel channel,
// and lets the cell checker compare every emitted cell with its prediction.
// ----------------------------------------------------------------------------
module tb_line_scan_converter;

  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  // Number of random segments after the directed ones.
  localparam int RANDOM_SEGMENTS = 500;
  // Cycles allowed after the last cell so that a stray extra cell shows up.
  localparam int DRAIN_CYCLES    = 16;
  // The slowest correct run is about 520 segments of 64 cells each, every
  // cell held back by the receiver now and then; this is far above that.
  localparam int CYCLE_LIMIT     = 500000;
  // Percentage of cycles in which either side idles outside the steady part.
  localparam int IDLE_PERCENT    = 26;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic steady;
  int   cycle_count = 0;
  int   mismatch_count;
  int   cells_pending;

  lsc_seg_if seg_if ();
  lsc_pix_if pix_if ();

  line_scan_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if),
    .pix_o  (pix_if)
  );

  lsc_cell_checker u_cell_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seg            (seg_if),
    .pix            (pix_if),
    .mismatch_count (mismatch_count),
    .cells_pending  (cells_pending)
  );

  always #5ns clk_i = ~clk_i;

  // The receiver holds ready low in about a quarter of the cycles, except in
  // the steady part of the run where it takes every cell at once.
  always @(posedge clk_i) begin
    pix_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog: a hung handshake or a missing cell ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_line_scan_converter NOT OK");
      $finish;
    end
  end

  // Offer one segment and return at the clock edge of its transfer. Valid
  // stays high on return, so back to back segments keep it up; a gap lowers
  // it at the edge right after the previous transfer.
  task automatic send_segment(input logic [IN_W-1:0] sr, input logic [IN_W-1:0] sc,
                              input logic [IN_W-1:0] er, input logic [IN_W-1:0] ec);
    while (!steady && ($urandom_range(99) < IDLE_PERCENT)) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid     <= 1'b1;
    seg_if.start_row <= sr;
    seg_if.start_col <= sc;
    seg_if.end_row   <= er;
    seg_if.end_col   <= ec;
    @(posedge clk_i);
    while (!seg_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Coordinates lean toward both ends of the range so that saturation at the
  // grid edge and the first cells are reached often.
  function automatic logic [IN_W-1:0] random_coord();
    case ($urandom_range(9))
      0:       return IN_W'($urandom_range(1023, 992));
      1:       return IN_W'($urandom_range(31, 0));
      default: return IN_W'($urandom_range(1023, 0));
    endcase
  endfunction

  // A random segment is either axis aligned, short, or fully independent.
  // Short segments keep most runs quick, while the others reach full spans.
  task automatic send_random_segment();
    logic [IN_W-1:0] sr, sc, er, ec;
    sr = random_coord();
    sc = random_coord();
    er = random_coord();
    ec = random_coord();
    case ($urandom_range(9))
      0: ec = sc;
      1: er = sr;
      2, 3, 4: begin
        er = sr ^ IN_W'($urandom_range(63));
        ec = sc ^ IN_W'($urandom_range(63));
      end
      default: ;
    endcase
    send_segment(sr, sc, er, ec);
  endtask

  initial begin
    rst_ni           = 1'b0;
    steady           = 1'b0;
    seg_if.valid     = 1'b0;
    seg_if.start_row = '0;
    seg_if.start_col = '0;
    seg_if.end_row   = '0;
    seg_if.end_col   = '0;
    pix_if.ready     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Degenerate segments, at the origin and saturated at the far corner.
    send_segment(10'd0, 10'd0, 10'd0, 10'd0);
    send_segment(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    // Full diagonals; equal raw differences select the column walk.
    send_segment(10'd0, 10'd0, 10'd1015, 10'd1015);
    send_segment(10'd1015, 10'd0, 10'd0, 10'd1015);
    send_segment(10'd0, 10'd1023, 10'd1023, 10'd0);
    // Full column and full row, each given in both directions.
    send_segment(10'd0, 10'd80, 10'd1023, 10'd80);
    send_segment(10'd1023, 10'd80, 10'd0, 10'd80);
    send_segment(10'd320, 10'd1023, 10'd320, 10'd0);
    send_segment(10'd320, 10'd0, 10'd320, 10'd1023);
    // Raw columns differ but round to the same cell, so rows are walked.
    send_segment(10'd0, 10'd8, 10'd100, 10'd23);
    // Column walk whose rounded row span exceeds its column span.
    send_segment(10'd7, 10'd0, 10'd24, 10'd18);
    // Shallow and steep walks with rising and falling minor axis.
    send_segment(10'd0, 10'd0, 10'd200, 10'd1000);
    send_segment(10'd1000, 10'd0, 10'd0, 10'd200);
    send_segment(10'd200, 10'd1000, 10'd0, 10'd0);
    send_segment(10'd600, 10'd300, 10'd100, 10'd320);
    send_segment(10'd16, 10'd16, 10'd48, 10'd800);
    send_segment(10'd0, 10'd0, 10'd16, 10'd1023);
    // Rounding boundary: seven rounds down, eight rounds up.
    send_segment(10'd7, 10'd7, 10'd8, 10'd8);
    // Values near the top of the range all land on the last cell.
    send_segment(10'd1008, 10'd1007, 10'd1009, 10'd1015);
    send_segment(10'd1023, 10'd0, 10'd1009, 10'd1023);
    // Alternating bit patterns on every field, then a shallow walk from the middle.
    send_segment(10'd682, 10'd341, 10'd341, 10'd682);
    send_segment(10'd341, 10'd682, 10'd682, 10'd341);
    send_segment(10'd512, 10'd512, 10'd520, 10'd700);

    // Random segments, with a stretch in the middle where neither side idles.
    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      steady = (i >= 200) && (i < 300);
      send_random_segment();
    end
    seg_if.valid <= 1'b0;
    steady = 1'b0;

    // The checker's pending count is registered, so it lags behind the last transfer.
    @(posedge clk_i);
    while (cells_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_line_scan_converter OK");
    end else begin
      $display("tb_line_scan_converter NOT OK");
    end
    $finish;
  end

endmodule
